// ===== sv/assert_macros.svh =====
// Assertion macros shared by the resonator cascade RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ZDF_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ZDF_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/zdfrc_pkg.sv =====
// Package for the resonator cascade: coefficient register layout,
// configuration port sizes and default parameter values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zdfrc_pkg;

	// Default sizes handed to the top level
	localparam int SECTIONS_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int STATE_BITS_DEF  = 32;

	// Coefficient register file
	localparam int MAX_SECTIONS = 8;
	localparam int CIDX_W       = 3;
	localparam int COEF_W       = 56;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_ADDR_W   = 6;
	localparam int CFG_LSB      = 3;
	localparam int FIELD_W      = 18;

	// Reset value: bypass set, everything else zero
	localparam logic [COEF_W-1:0] COEF_RESET = {1'b1, {(COEF_W-1){1'b0}}};

	// Packed coefficient layout, MSB first
	typedef struct packed {
		logic               bypass;
		logic               anti;
		logic [FIELD_W-1:0] k1;
		logic [FIELD_W-1:0] damp;
		logic [FIELD_W-1:0] g;
	} coef_t;

endpackage

`default_nettype wire

// ===== sv/zdf_resonator_cascade.sv =====
// Resonator cascade top level: sequencer, shared multiplier, state memory.
// Depends on zdfrc_pkg and assert_macros.svh.
//
//  channel  signals                                        direction   meaning
//  in       in_valid, in_stall, sample_in                  to block    one sample request
//  out      out_valid, out_stall, sample_out, saturated    from block  one filtered sample
//  cfg      psel, penable, pwrite, paddr, pwdata, prdata   both        coef regs, 8 bytes apart
//
// A sample passes the sequencer steps once per section, with the one shared
// multiplier doing the products: four dependent products per active section, each
// registered before its result is used; a bypassed section takes no products.
// Reset clears control, the state valid bits and the coefficient valid bits; no
// clearing pass. A new request is taken while the previous result waits in the
// output register; a finished sample waits in its last step while that register
// is still held by out_stall.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module zdf_resonator_cascade
	import zdfrc_pkg::*;
#(
	parameter int SECTIONS    = SECTIONS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int STATE_BITS  = STATE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	// sample output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          saturated,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CFG_ADDR_W-1:0]         paddr,
	input  logic [CFG_DATA_W-1:0]         pwdata,
	output logic [CFG_DATA_W-1:0]         prdata,
	output logic                          pready
);

	localparam int SB    = STATE_BITS;
	localparam int SMB   = SAMPLE_BITS;
	localparam int AW    = SB + 8;
	localparam int PW    = SB + FIELD_W + 1;
	localparam int DIFF  = (SB - 8) - (SMB - 1);
	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

	localparam logic signed [AW-1:0] ST_HI  = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [AW-1:0] ST_LO  = {{(AW-SB+1){1'b1}}, {(SB-1){1'b0}}};
	localparam logic signed [AW-1:0] OUT_HI = {{(AW-SMB+1){1'b0}}, {(SMB-1){1'b1}}};
	localparam logic signed [AW-1:0] OUT_LO = {{(AW-SMB+1){1'b1}}, {(SMB-1){1'b0}}};
	localparam logic signed [PW:0]   HALF14 = (PW+1)'(1) << 13;
	localparam logic signed [PW:0]   HALF18 = (PW+1)'(1) << 17;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_LOAD, ST_U, ST_MK, ST_V0,
		ST_MG0, ST_V1, ST_MG1, ST_V2, ST_WB, ST_OUT
	} state_t;

	function automatic logic signed [SB-1:0] sat_st(input logic signed [AW-1:0] v);
		if (v > ST_HI) return ST_HI[SB-1:0];
		if (v < ST_LO) return ST_LO[SB-1:0];
		return v[SB-1:0];
	endfunction

	function automatic logic clip_st(input logic signed [AW-1:0] v);
		return (v > ST_HI) || (v < ST_LO);
	endfunction

	// ---------------------------------------------------------------
	// Control registers
	state_t                state_q;
	logic [SEC_W-1:0]      sec_q;
	logic                  out_valid_q;
	logic signed [SMB-1:0] sample_out_q;
	logic                  saturated_q;

	// Datapath registers
	logic signed [SB-1:0]  x_q, s1_q, s2_q, u_q, v0_q, v1_q, v2_q;
	logic signed [AW-1:0]  gv0_q, gv1_q;
	logic [FIELD_W-1:0]    g_q, k1_q;
	logic                  anti_q;
	logic                  sat_q;
	logic signed [PW-1:0]  prod_s1;

	// Memories and their read registers
	logic [COEF_W-1:0]     coef_mem [MAX_SECTIONS];
	logic [MAX_SECTIONS-1:0] coef_valid_q;
	logic [COEF_W-1:0]     co_rdata_q, co_pdata_q;
	logic                  co_rvalid_q, co_pvalid_q;
	logic [2*SB-1:0]       state_mem [SECTIONS];
	logic [SECTIONS-1:0]   st_valid_q;
	logic [2*SB-1:0]       st_rdata_q;
	logic                  st_rvalid_q;

	// Combinational
	logic                  in_acc, out_acc, cfg_we, st_we, skip, last_sec, out_free;
	logic                  out_load;
	coef_t                 cf;
	logic signed [SB-1:0]  s1_rd, s2_rd, x_in;
	logic signed [SB-1:0]  mul_a;
	logic [FIELD_W-1:0]    mul_c;
	logic signed [PW:0]    prod_ext, r14_sum, r18_sum;
	logic signed [AW-1:0]  r14, r18;
	logic signed [AW-1:0]  u_sum, v1_sum, v2_sum, s1n_sum, s2n_sum, y_sum, conv;
	logic                  conv_clip;
	logic signed [SMB-1:0] conv_sat;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign in_stall = (state_q != ST_IDLE);
	assign last_sec = (sec_q == SEC_LAST);
	assign st_we    = (state_q == ST_WB);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;
	assign pready     = 1'b1;
	assign prdata     = CFG_DATA_W'(co_pvalid_q ? co_pdata_q : COEF_RESET);

	// Entries never written read as reset values
	assign cf    = coef_t'(co_rvalid_q ? co_rdata_q : COEF_RESET);
	assign s1_rd = st_rvalid_q ? st_rdata_q[SB-1:0]    : '0;
	assign s2_rd = st_rvalid_q ? st_rdata_q[2*SB-1:SB] : '0;
	assign skip  = cf.bypass || (cf.g == '0);

	// ---------------------------------------------------------------
	// Input alignment to the internal Q8 format
	generate
		if (DIFF >= 0) begin : gen_in_shl
			assign x_in = SB'(AW'(sample_in) <<< DIFF);
		end else begin : gen_in_shr
			localparam int RS = -DIFF;
			localparam logic signed [AW-1:0] IN_HALF = AW'(1) << (RS - 1);
			logic signed [AW-1:0] in_sum;
			assign in_sum = AW'(sample_in) + IN_HALF;
			assign x_in   = SB'(in_sum >>> RS);
		end
	endgenerate

	// Output conversion to the sample format
	generate
		if (DIFF > 0) begin : gen_out_shr
			localparam logic signed [AW-1:0] OUT_HALF = AW'(1) << (DIFF - 1);
			logic signed [AW-1:0] out_sum;
			assign out_sum = AW'(x_q) + OUT_HALF;
			assign conv    = out_sum >>> DIFF;
		end else if (DIFF == 0) begin : gen_out_eq
			assign conv = AW'(x_q);
		end else begin : gen_out_shl
			assign conv = AW'(x_q) <<< (-DIFF);
		end
	endgenerate

	always_comb begin
		conv_clip = (conv > OUT_HI) || (conv < OUT_LO);
		if (conv > OUT_HI) begin
			conv_sat = OUT_HI[SMB-1:0];
		end else if (conv < OUT_LO) begin
			conv_sat = OUT_LO[SMB-1:0];
		end else begin
			conv_sat = conv[SMB-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_LOAD: begin
				mul_a = s1_rd;
				mul_c = cf.damp;
			end
			ST_MK: begin
				mul_a = u_q;
				mul_c = k1_q;
			end
			ST_MG0: begin
				mul_a = v0_q;
				mul_c = g_q;
			end
			ST_MG1: begin
				mul_a = v1_q;
				mul_c = g_q;
			end
			default: begin
				mul_a = '0;
				mul_c = '0;
			end
		endcase
	end

	// Product rounding, half up, in the signal operand's format
	assign prod_ext = (PW+1)'(prod_s1);
	assign r14_sum  = prod_ext + HALF14;
	assign r18_sum  = prod_ext + HALF18;
	assign r14      = AW'(r14_sum >>> 14);
	assign r18      = AW'(r18_sum >>> 18);

	// Section adders
	assign u_sum   = AW'(x_q) - r14 - AW'(s2_q);
	assign v1_sum  = AW'(s1_q) + r14;
	assign v2_sum  = AW'(s2_q) + r14;
	assign s1n_sum = AW'(v1_q) + gv0_q;
	assign s2n_sum = AW'(v2_q) + gv1_q;
	assign y_sum   = AW'(x_q) - AW'(v0_q);

	// ---------------------------------------------------------------
	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sec_q        <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			saturated_q  <= 1'b0;
			st_valid_q   <= '0;
			coef_valid_q <= '0;
		end else begin
			// A new result replaces the one leaving in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				coef_valid_q[paddr[CFG_LSB +: CIDX_W]] <= 1'b1;
			end
			if (st_we) begin
				st_valid_q[sec_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sec_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (!skip) begin
						state_q <= ST_U;
					end else if (last_sec) begin
						state_q <= ST_OUT;
					end else begin
						sec_q   <= sec_q + SEC_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_U:   state_q <= ST_MK;
				ST_MK:  state_q <= ST_V0;
				ST_V0:  state_q <= ST_MG0;
				ST_MG0: state_q <= ST_V1;
				ST_V1:  state_q <= ST_MG1;
				ST_MG1: state_q <= ST_V2;
				ST_V2:  state_q <= ST_WB;
				ST_WB: begin
					if (last_sec) begin
						state_q <= ST_OUT;
					end else begin
						sec_q   <= sec_q + SEC_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						sample_out_q <= conv_sat;
						saturated_q  <= sat_q | conv_clip;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Section datapath
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * $signed({1'b0, mul_c});
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q   <= x_in;
					sat_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				s1_q   <= s1_rd;
				s2_q   <= s2_rd;
				g_q    <= cf.g;
				k1_q   <= cf.k1;
				anti_q <= cf.anti;
			end
			ST_U: begin
				u_q   <= sat_st(u_sum);
				sat_q <= sat_q | clip_st(u_sum);
			end
			ST_V0: begin
				v0_q  <= sat_st(r18);
				sat_q <= sat_q | clip_st(r18);
			end
			ST_V1: begin
				gv0_q <= r14;
				v1_q  <= sat_st(v1_sum);
				sat_q <= sat_q | clip_st(v1_sum);
			end
			ST_V2: begin
				gv1_q <= r14;
				v2_q  <= sat_st(v2_sum);
				sat_q <= sat_q | clip_st(v2_sum);
			end
			ST_WB: begin
				x_q   <= anti_q ? sat_st(y_sum) : v0_q;
				sat_q <= sat_q | clip_st(s1n_sum) | clip_st(s2n_sum)
					| (anti_q & clip_st(y_sum));
			end
			default: begin
			end
		endcase
	end

	// Integrator state memory: read every cycle at the current section,
	// written back once per active section. One section is in flight at a
	// time; the read made in the write-back step returns the old entry, unused.
	always_ff @(posedge clk) begin
		if (st_we) begin
			state_mem[sec_q] <= {sat_st(s2n_sum), sat_st(s1n_sum)};
		end
		st_rdata_q  <= state_mem[sec_q];
		st_rvalid_q <= st_valid_q[sec_q];
	end

	// Coefficient memory: bus write port, bus read port, sequencer read port
	always_ff @(posedge clk) begin
		if (cfg_we) begin
			coef_mem[paddr[CFG_LSB +: CIDX_W]] <= pwdata[COEF_W-1:0];
		end
		co_pdata_q  <= coef_mem[paddr[CFG_LSB +: CIDX_W]];
		co_pvalid_q <= coef_valid_q[paddr[CFG_LSB +: CIDX_W]];
		co_rdata_q  <= coef_mem[CIDX_W'(sec_q)];
		co_rvalid_q <= coef_valid_q[CIDX_W'(sec_q)];
	end

	// ---------------------------------------------------------------
	// Checks
	`ZDF_ASSERT_NXT(a_accept_starts, clk, arst_n, in_acc, state_q == ST_READ,
		"request not started")
	`ZDF_ASSERT_NXT(a_out_waits, clk, arst_n, (state_q == ST_OUT) && !out_free,
		state_q == ST_OUT, "result overwrote held output")
	`ZDF_ASSERT_IMP(a_sec_range, clk, arst_n, state_q != ST_IDLE, sec_q <= SEC_LAST,
		"section index out of range")
	`ZDF_ASSERT_IMP(a_sec_step, clk, arst_n,
		(state_q == ST_READ) && ($past(state_q) != ST_IDLE),
		sec_q == $past(sec_q) + SEC_W'(1), "section skipped")

endmodule

`default_nettype wire

// ===== tb/sv/resonator_checker.sv =====
`timescale 1ns / 1ps
// Checker for the resonator cascade: predicts each filtered sample and checks the output channel.
// Watches the sample channels and the coefficient write port. Depends on zdfrc_pkg.

module resonator_checker
	import zdfrc_pkg::*;
#(
	parameter int SECTIONS    = SECTIONS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int STATE_BITS  = STATE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          saturated,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [CFG_ADDR_W-1:0]         paddr,
	input  logic [CFG_DATA_W-1:0]         pwdata,
	output int                            errors,
	output int                            pending
);

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clip;
	} filtered_t;

	// Shadow copy of the coefficient registers and the integrator states
	coef_t     coef_copy [MAX_SECTIONS];
	longint    integ_one [MAX_SECTIONS];
	longint    integ_two [MAX_SECTIONS];
	filtered_t predicted_samples [$];
	filtered_t want;
	bit        clip_seen;
	int        mismatches;

	// Clip to a signed range of the given width, noting any clipping
	function automatic longint clip_to(input longint v, input int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip_seen = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip_seen = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint round_half_up(input longint v, input int n);
		if (n == 0)
			return v;
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	// Signal times unsigned coefficient, scaled down by 2^sh with round half up
	function automatic longint scale_by(input longint a, input longint c, input int sh);
		return (a * c + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	// One resonator section; updates its integrators unless it passes through
	function automatic longint resonate(input int i, input longint x);
		coef_t  c;
		longint g, d, k, s1, s2, u, v0, v1, v2, gv0, gv1;
		c = coef_copy[i];
		if (c.bypass || c.g == '0)
			return x;
		g   = longint'(c.g);
		d   = longint'(c.damp);
		k   = longint'(c.k1);
		s1  = integ_one[i];
		s2  = integ_two[i];
		u   = clip_to(x - scale_by(s1, d, 14) - s2, STATE_BITS);
		v0  = clip_to(scale_by(u, k, 18), STATE_BITS);
		gv0 = scale_by(v0, g, 14);
		v1  = clip_to(s1 + gv0, STATE_BITS);
		gv1 = scale_by(v1, g, 14);
		v2  = clip_to(s2 + gv1, STATE_BITS);
		integ_one[i] = clip_to(v1 + gv0, STATE_BITS);
		integ_two[i] = clip_to(v2 + gv1, STATE_BITS);
		if (c.anti)
			return clip_to(x - v0, STATE_BITS);
		return v0;
	endfunction

	// Full cascade for one sample request
	function automatic filtered_t filter_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		longint    x, y;
		int        shift;
		filtered_t res;
		clip_seen = 1'b0;
		shift = (STATE_BITS - 8) - (SAMPLE_BITS - 1);
		if (shift >= 0)
			x = longint'(smp) <<< shift;
		else
			x = round_half_up(longint'(smp), -shift);
		x = clip_to(x, STATE_BITS);
		for (int i = 0; i < SECTIONS && i < MAX_SECTIONS; i++)
			x = resonate(i, x);
		if (shift >= 0)
			y = round_half_up(x, shift);
		else
			y = x <<< -shift;
		y = clip_to(y, SAMPLE_BITS);
		res.sample = y[SAMPLE_BITS-1:0];
		res.clip   = clip_seen;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				coef_copy[i] = COEF_RESET;
				integ_one[i] = 0;
				integ_two[i] = 0;
			end
			predicted_samples.delete();
			mismatches = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// Coefficient write completes in the access phase
			if (psel && penable && pwrite && pready)
				coef_copy[paddr[CFG_LSB +: CIDX_W]] = pwdata[COEF_W-1:0];
			// Accepted sample request: predict its result
			if (in_valid && !in_stall)
				predicted_samples.push_back(filter_sample(sample_in));
			// Accepted result: compare against the oldest prediction
			if (out_valid && !out_stall) begin
				if (predicted_samples.size() == 0) begin
					$error("unexpected result: sample_out=%0d saturated=%0b",
						sample_out, saturated);
					mismatches++;
				end else begin
					want = predicted_samples.pop_front();
					if (sample_out !== want.sample) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							want.sample, sample_out);
						mismatches++;
					end
					if (saturated !== want.clip) begin
						$error("saturated mismatch: expected %0b, actual %0b",
							want.clip, saturated);
						mismatches++;
					end
				end
			end
			errors  <= mismatches;
			pending <= predicted_samples.size();
		end
	end

endmodule

// ===== tb/sv/zdf_resonator_cascade_tb.sv =====
`timescale 1ns / 1ps
// Top of the resonator cascade testbench: clock, reset, sample stimulus, coefficient writes.
// Depends on zdfrc_pkg, zdf_resonator_cascade and resonator_checker.

module zdf_resonator_cascade_tb
	import zdfrc_pkg::*;
();

	localparam int SECTIONS      = SECTIONS_DEF;
	localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
	localparam int STATE_BITS    = STATE_BITS_DEF;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 65;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          saturated;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [CFG_ADDR_W-1:0]         paddr     = '0;
	logic [CFG_DATA_W-1:0]         pwdata    = '0;
	logic [CFG_DATA_W-1:0]         prdata;
	logic                          pready;

	int errors;
	int pending;
	int gap_pct       = 0;
	int stall_pct     = 0;
	int hold_reqs     = 0;
	int holds_started = 0;
	int hold_left     = 0;
	logic signed [SAMPLE_BITS-1:0] last_sample = '0;

	always #6 clk = ~clk;

	zdf_resonator_cascade #(
		.SECTIONS    (SECTIONS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.STATE_BITS  (STATE_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.saturated  (saturated),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	resonator_checker #(
		.SECTIONS    (SECTIONS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.STATE_BITS  (STATE_BITS)
	) CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.saturated  (saturated),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.errors     (errors),
		.pending    (pending)
	);

	// Receiver: random stall, or a long hold-off counted here when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_started != hold_reqs) begin
			out_stall     <= 1'b1;
			hold_left     <= HOLD_CYCLES;
			holds_started <= holds_started + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog
	initial begin
		#(10_000_000);
		$display("Test completed with failures");
		$finish;
	end

	task automatic set_idle(input idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				gap_pct = 0;
				stall_pct <= 0;
			end
			IDLE_SENDER: begin
				gap_pct = 73;
				stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct <= 73;
			end
			default: begin
				gap_pct = 15;
				stall_pct <= 15;
			end
		endcase
	endtask

	// Offer one sample request and hold it until accepted, then maybe idle
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
		in_valid    <= 1'b1;
		sample_in   <= s;
		last_sample = s;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < gap_pct) begin
			in_valid  <= 1'b0;
			sample_in <= SAMPLE_BITS'($urandom);
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
	endtask

	// Stop offering and wait until every predicted sample has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; register is written at the access edge
	task automatic write_coef(input int idx, input logic [CFG_DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(idx << CFG_LSB);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Coefficients of a plausible resonator: k1 = 1/(1 + 2R*g + g*g) in fixed point
	function automatic logic [CFG_DATA_W-1:0] tuned_coef(input bit anti);
		longint g, d, den, k;
		if ($urandom_range(3) == 0)
			g = $urandom_range(163840, 300);
		else
			g = $urandom_range(16384, 200);
		d   = $urandom_range(32768, 100);
		den = 16384 + ((d * g) >> 14) + ((g * g) >> 14);
		k   = (longint'(1) << 32) / den;
		if (k > 262143)
			k = 262143;
		return {8'($urandom), 1'b0, anti, 18'(k), 18'(d), 18'(g)};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_coef();
		case ($urandom_range(9))
			0:       return {$urandom, $urandom} | (64'd1 << 55);
			1:       return {$urandom, $urandom} & ~64'h3FFFF;
			2, 3:    return {$urandom, $urandom};
			default: return tuned_coef($urandom_range(3) == 0);
		endcase
	endfunction

	// Mix of extremes, held levels (steps), small values and full-range noise
	function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
		case ($urandom_range(9))
			0:       return SMP_MIN;
			1:       return SMP_MAX;
			2, 3:    return last_sample;
			4:       return SAMPLE_BITS'(int'($urandom_range(512)) - 256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] cfg;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: every section bypassed
		set_idle(IDLE_NONE);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		send_sample('0);
		send_sample(SAMPLE_BITS'(-1));
		send_sample(SAMPLE_BITS'(1));
		send_sample(SAMPLE_BITS'(16'h5555));
		wait_drained();

		// Register extremes: bypass with anti, zero g with anti, full-scale fields,
		// zero k1, minimum g
		write_coef(0, '1);
		write_coef(1, {8'h00, 1'b0, 1'b1, 18'h3FFFF, 18'h3FFFF, 18'h00000});
		write_coef(2, {8'hFF, 1'b0, 1'b0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF});
		write_coef(3, {8'h00, 1'b0, 1'b1, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF});
		write_coef(4, tuned_coef(1'b0));
		write_coef(5, tuned_coef(1'b1));
		write_coef(6, {8'h00, 1'b0, 1'b0, 18'h00000, 18'h00000, 18'd1});
		write_coef(7, {8'h00, 1'b0, 1'b0, 18'h3FFFF, 18'h00000, 18'd1});
		repeat (4) send_sample(SMP_MAX);
		repeat (4) send_sample(SMP_MIN);
		repeat (3) send_sample('0);
		send_sample(SAMPLE_BITS'(1));
		send_sample(SAMPLE_BITS'(-1));
		send_sample(SAMPLE_BITS'(12345));
		wait_drained();

		// Random phases, each with new coefficients and its own idling pattern
		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				if (p == 3)
					cfg = '0;
				else if (p == 6)
					cfg = {8'h00, 1'b0, 1'b1, {54{1'b1}}};
				else
					cfg = random_coef();
				write_coef(i, cfg);
			end
			set_idle(idle_mode_t'(p % 4));
			// Long receiver hold-off while the sender keeps offering
			if (p == 4)
				hold_reqs <= hold_reqs + 1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Sender pause until every result is out
				if (p == 5 && k == PHASE_ITEMS / 2)
					wait_drained();
				send_sample(next_sample());
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
